@@ rtl/ptrm_pkg.sv @@
// ----------------------------------------------------------------------------
// ptrm_pkg
// Shared types and codes of the page table run mapper.
// ----------------------------------------------------------------------------
package ptrm_pkg;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_MAP    = 2'd1,
    FUNC_UNMAP  = 2'd2,
    FUNC_FIND   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_NOFIT = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  localparam int unsigned FrameW = 20;
  localparam int unsigned FlagW  = 8;
  localparam int unsigned EntryW = FrameW + FlagW;
  localparam int unsigned CountW = 13;
  localparam int unsigned PageW  = 12;

  typedef struct packed {
    func_e               func;
    logic [PageW-1:0]    page;
    logic [FrameW-1:0]   frame;
    logic [CountW-1:0]   count;
    logic [FlagW-1:0]    flags;
  } in_t;

  typedef struct packed {
    logic [31:0]         entry;
    logic [PageW-1:0]    found_page;
    status_e             status;
  } out_t;

endpackage

@@ rtl/ptrm_ram.sv @@
// ----------------------------------------------------------------------------
// ptrm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ptrm_ram #(
  parameter int unsigned Width = 28,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ptrm_seq.sv @@
// ----------------------------------------------------------------------------
// ptrm_seq
// Operation sequencer: clears the table after reset, then runs one lookup,
// map, unmap or find at a time against the entry RAM.
// ----------------------------------------------------------------------------
module ptrm_seq #(
  parameter int unsigned Pages = 4096,
  localparam int unsigned AddrW = $clog2(Pages)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  ptrm_pkg::in_t                 in_i,
  output logic                          in_stall_o,
  output logic                          res_valid_o,
  output ptrm_pkg::out_t                res_o,
  input  logic                          res_take_i,
  output logic                          ram_we_o,
  output logic [AddrW-1:0]              ram_waddr_o,
  output logic [ptrm_pkg::EntryW-1:0]   ram_wdata_o,
  output logic                          ram_re_o,
  output logic [AddrW-1:0]              ram_raddr_o,
  input  logic [ptrm_pkg::EntryW-1:0]   ram_rdata_i
);

  // PtrW holds a page index up to and including Pages itself.
  localparam int unsigned PtrW = AddrW + 1;
  // CmpW holds page + count of an input item and Pages.
  localparam int unsigned CmpW = (PtrW > 14) ? PtrW : 14;
  // SubW holds the start page arithmetic of find.
  localparam int unsigned SubW = ((AddrW > ptrm_pkg::CountW) ? AddrW : ptrm_pkg::CountW) + 1;
  localparam logic [CmpW-1:0] PagesCmp = CmpW'(Pages);
  localparam logic [PtrW-1:0] PagesPtr = PtrW'(Pages);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Pages - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_LOOK  = 6'b000100,
    S_WRITE = 6'b001000,
    S_FIND  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e                        state_q, state_d;
  logic [PtrW-1:0]               cur_q, cur_d;
  logic [ptrm_pkg::CountW-1:0]   rem_q, rem_d;
  logic [ptrm_pkg::FrameW-1:0]   frame_q, frame_d;
  logic [ptrm_pkg::FlagW-1:0]    flags_q, flags_d;
  logic                          unmap_q, unmap_d;
  logic [ptrm_pkg::CountW-1:0]   run_q, run_d;
  logic                          pend_q, pend_d;
  logic [AddrW-1:0]              pend_addr_q, pend_addr_d;
  ptrm_pkg::out_t                res_q, res_d;

  logic [CmpW-1:0]               page_ext, end_ext;
  logic                          issue;
  logic [ptrm_pkg::CountW-1:0]   run_next;
  logic [SubW-1:0]               start_w;

  assign page_ext = CmpW'(in_i.page);
  assign end_ext  = page_ext + CmpW'(in_i.count);
  assign issue    = cur_q < PagesPtr;
  assign run_next = ram_rdata_i[0] ? '0 : run_q + 1'b1;
  assign start_w  = SubW'(pend_addr_q) + SubW'(1) - SubW'(rem_q);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    rem_d       = rem_q;
    frame_d     = frame_q;
    flags_d     = flags_q;
    unmap_d     = unmap_q;
    run_d       = run_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = cur_q[AddrW-1:0];
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = cur_q[AddrW-1:0];

    unique case (state_q)
      S_CLEAR: begin
        ram_we_o = 1'b1;
        cur_d    = cur_q + 1'b1;
        if (cur_q == LastPtr) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          res_d.entry      = '0;
          res_d.found_page = '0;
          res_d.status     = ptrm_pkg::ST_DONE;
          rem_d            = in_i.count;
          frame_d          = in_i.frame;
          flags_d          = in_i.flags;
          unmap_d          = in_i.func == ptrm_pkg::FUNC_UNMAP;
          unique case (in_i.func)
            ptrm_pkg::FUNC_LOOKUP: begin
              if (page_ext < PagesCmp) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = AddrW'(page_ext);
                state_d     = S_LOOK;
              end else begin
                res_d.status = ptrm_pkg::ST_RANGE;
                state_d      = S_RESP;
              end
            end
            ptrm_pkg::FUNC_MAP, ptrm_pkg::FUNC_UNMAP: begin
              if (in_i.count == '0) begin
                state_d = S_RESP;
              end else if (end_ext > PagesCmp) begin
                res_d.status = ptrm_pkg::ST_RANGE;
                state_d      = S_RESP;
              end else begin
                cur_d   = PtrW'(page_ext);
                state_d = S_WRITE;
              end
            end
            ptrm_pkg::FUNC_FIND: begin
              res_d.status = ptrm_pkg::ST_NOFIT;
              if (in_i.count == '0 || page_ext >= PagesCmp) begin
                state_d = S_RESP;
              end else begin
                cur_d   = PtrW'(page_ext);
                run_d   = '0;
                pend_d  = 1'b0;
                state_d = S_FIND;
              end
            end
          endcase
        end
      end

      S_LOOK: begin
        res_d.entry = {ram_rdata_i[ptrm_pkg::EntryW-1:ptrm_pkg::FlagW], 4'b0000,
                       ram_rdata_i[ptrm_pkg::FlagW-1:0]};
        state_d     = S_RESP;
      end

      S_WRITE: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = unmap_q ? '0 : {frame_q, flags_q};
        cur_d       = cur_q + 1'b1;
        frame_d     = frame_q + 1'b1;
        rem_d       = rem_q - 1'b1;
        if (rem_q == ptrm_pkg::CountW'(1)) begin
          state_d = S_RESP;
        end
      end

      S_FIND: begin
        // Reads stream one entry per cycle; the entry read in the previous
        // cycle is scored against the free run length here.
        if (issue) begin
          ram_re_o = 1'b1;
          cur_d    = cur_q + 1'b1;
        end
        pend_d      = issue;
        pend_addr_d = cur_q[AddrW-1:0];
        if (pend_q) begin
          run_d = run_next;
          if (run_next == rem_q) begin
            res_d.status     = ptrm_pkg::ST_DONE;
            res_d.found_page = start_w[ptrm_pkg::PageW-1:0];
            state_d          = S_RESP;
          end
        end else if (!issue) begin
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cur_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    frame_q     <= frame_d;
    flags_q     <= flags_d;
    unmap_q     <= unmap_d;
    run_q       <= run_d;
    pend_addr_q <= pend_addr_d;
    res_q       <= res_d;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign res_valid_o = state_q == S_RESP;
  assign res_o       = res_q;

endmodule

@@ rtl/page_table_run_mapper.sv @@
// ----------------------------------------------------------------------------
// page_table_run_mapper
// Flat page table with lookup, run map, run unmap and first-fit free run find.
// ----------------------------------------------------------------------------
// Usage: one operation is presented on in_i with in_valid_i and is taken on a
// clock edge where in_stall_o is low; each operation yields exactly one result
// on out_o, offered with out_valid_o and taken when out_stall_i is low.
// Operations run one at a time against the entry RAM, which has one write
// port and one registered read port, so a new operation is accepted only
// after the previous one has handed its result to the output register.
// Map or unmap writes one entry per cycle, and find reads one entry per
// cycle until it finds a fitting free run or passes the last page.
// After reset the RAM is swept to zero at one entry per cycle, so in_stall_o
// stays high until every entry has been cleared.
// A result waiting in the output register does not block the next operation;
// while the receiver stalls, that result holds and the following one waits
// inside the sequencer.
// ----------------------------------------------------------------------------
module page_table_run_mapper #(
  parameter int unsigned Pages = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  ptrm_pkg::in_t  in_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output ptrm_pkg::out_t out_o,
  input  logic           out_stall_i
);

  localparam int unsigned AddrW = $clog2(Pages);

  logic                        res_valid;
  ptrm_pkg::out_t              res;
  logic                        res_take;
  logic                        ram_we, ram_re;
  logic [AddrW-1:0]            ram_waddr, ram_raddr;
  logic [ptrm_pkg::EntryW-1:0] ram_wdata, ram_rdata;

  logic           out_valid_q, out_valid_d;
  ptrm_pkg::out_t out_q;

  ptrm_seq #(
    .Pages (Pages)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  ptrm_ram #(
    .Width (ptrm_pkg::EntryW),
    .Depth (Pages)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The output register takes a new result when it is empty or its current
  // transfer completes in this cycle.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A result is only offered while the sequencer holds off new input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_stall_o)
    else $error("result offered while sequencer accepts input");

  // Only a successful lookup carries a nonzero entry; failed operations
  // report nothing but their status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == ptrm_pkg::ST_RANGE ||
                    out_o.status == ptrm_pkg::ST_NOFIT)
    |-> out_o.entry == '0 && out_o.found_page == '0)
    else $error("failed operation returned payload data");

  // Find and lookup never both fill in a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.entry == '0 || out_o.found_page == '0)
    else $error("result carries both an entry and a found page");

  // A transfer into the output register needs a free or draining slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> !$past(res_take))
    else $error("output register overwritten while stalled");

endmodule
